>>> design/arp_table_lru_cache_unit_macros.svh
// ----------------------------------------------------------------------------
// ARP table cache assertion macros
// Concurrent assertion wrappers on clk and rst_n; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ARP_TABLE_LRU_CACHE_UNIT_MACROS_SVH
`define ARP_TABLE_LRU_CACHE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge out of reset.
`define ARPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that cond never holds at a clock edge out of reset.
`define ARPC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ARPC_ASSERT(lbl, prop, msg)
`define ARPC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> design/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP table cache package
// Shared widths, opcodes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int SLOT_W = 4;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DECIDE,
    ST_PROMOTE,
    ST_PROM_WAIT,
    ST_DONE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture request fields, clear scan trackers
    logic cnt_clr;    // restart the entry counter
    logic rd_en;      // read the entry at the counter and advance
    logic promote;    // read belongs to the promote pass
    logic decide;     // pick target slot and build result
    logic publish;    // move result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;       // counter sits on the last entry
    logic is_lookup;  // captured request is a lookup
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

>>> design/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// ARP table cache controller
// Sequences scan, decide, promote and result hand-off for one request.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  arpc_pkg::sts_t  sts,
  output arpc_pkg::cmd_t  cmd
);

  arpc_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arpc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = arpc_pkg::ST_SCAN;
      end
      arpc_pkg::ST_SCAN: begin
        if (sts.last) state_nxt = arpc_pkg::ST_SCAN_WAIT;
      end
      arpc_pkg::ST_SCAN_WAIT: begin
        state_nxt = arpc_pkg::ST_DECIDE;
      end
      arpc_pkg::ST_DECIDE: begin
        state_nxt = sts.is_lookup ? arpc_pkg::ST_DONE : arpc_pkg::ST_PROMOTE;
      end
      arpc_pkg::ST_PROMOTE: begin
        if (sts.last) state_nxt = arpc_pkg::ST_PROM_WAIT;
      end
      arpc_pkg::ST_PROM_WAIT: begin
        state_nxt = arpc_pkg::ST_DONE;
      end
      arpc_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = arpc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = arpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      arpc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.cnt_clr = 1'b1;
        end
      end
      arpc_pkg::ST_SCAN: begin
        cmd.rd_en = 1'b1;
      end
      arpc_pkg::ST_DECIDE: begin
        cmd.decide  = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      arpc_pkg::ST_PROMOTE: begin
        cmd.rd_en   = 1'b1;
        cmd.promote = 1'b1;
      end
      arpc_pkg::ST_DONE: begin
        cmd.publish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> design/arpc_datapath.sv
// ----------------------------------------------------------------------------
// ARP table cache datapath
// Entry memory, valid bits, scan trackers, replacement choice and output stage.
// ----------------------------------------------------------------------------
module arpc_datapath #(
  parameter int TABLE_ENTRIES = arpc_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  arpc_pkg::cmd_t               cmd,
  output arpc_pkg::sts_t               sts,
  input  logic                         in_opcode,
  input  logic [arpc_pkg::IP_W-1:0]    in_ip_address,
  input  logic [arpc_pkg::MAC_W-1:0]   in_mac_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic [arpc_pkg::MAC_W-1:0]   out_found_mac,
  output logic [arpc_pkg::SLOT_W-1:0]  out_slot,
  output logic                         out_evicted
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int AGE_W = IDX_W;
  localparam int ENT_W = arpc_pkg::IP_W + arpc_pkg::MAC_W + AGE_W;

  // Request capture
  logic                        op_r;
  logic [arpc_pkg::IP_W-1:0]   ip_r;
  logic [arpc_pkg::MAC_W-1:0]  mac_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      ip_r  <= in_ip_address;
      mac_r <= in_mac_address;
    end
  end

  // Entry counter
  logic [IDX_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.rd_en) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Entry memory {ip, mac, age} and valid bits
  logic [ENT_W-1:0]         mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [ENT_W-1:0]         rd_data_r;
  logic                     rd_vbit_r;
  logic [IDX_W-1:0]         rd_idx_r;
  logic                     rd_vld_r;
  logic                     rd_prom_r;
  logic                     wr_en;
  logic [ENT_W-1:0]         wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[rd_idx_r] <= wr_data;
    if (cmd.rd_en) begin
      rd_data_r <= mem[cnt_r];
      rd_vbit_r <= valid_r[cnt_r];
      rd_idx_r  <= cnt_r;
      rd_prom_r <= cmd.promote;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
    end
  end

  logic [arpc_pkg::IP_W-1:0]  rd_ip;
  logic [arpc_pkg::MAC_W-1:0] rd_mac;
  logic [AGE_W-1:0]           rd_age;
  logic                       scan_ev;
  logic                       prom_ev;
  logic                       is_lookup;

  assign rd_ip     = rd_data_r[ENT_W-1 -: arpc_pkg::IP_W];
  assign rd_mac    = rd_data_r[AGE_W +: arpc_pkg::MAC_W];
  assign rd_age    = rd_data_r[AGE_W-1:0];
  assign scan_ev   = rd_vld_r && !rd_prom_r;
  assign prom_ev   = rd_vld_r && rd_prom_r;
  assign is_lookup = (op_r == arpc_pkg::OP_LOOKUP);

  // Scan trackers: best match, first free slot, oldest valid entry
  logic                       m_found_r;
  logic [IDX_W-1:0]           m_idx_r;
  logic [AGE_W-1:0]           m_age_r;
  logic [arpc_pkg::MAC_W-1:0] m_mac_r;
  logic                       free_found_r;
  logic [IDX_W-1:0]           free_idx_r;
  logic                       old_seen_r;
  logic [IDX_W-1:0]           old_idx_r;
  logic [AGE_W-1:0]           old_age_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      m_found_r    <= 1'b0;
      free_found_r <= 1'b0;
      old_seen_r   <= 1'b0;
    end else if (scan_ev) begin
      if (is_lookup) begin
        if (rd_vbit_r && rd_ip == ip_r && (!m_found_r || rd_age < m_age_r)) begin
          m_found_r <= 1'b1;
          m_idx_r   <= rd_idx_r;
          m_age_r   <= rd_age;
          m_mac_r   <= rd_mac;
        end
      end else if (rd_vbit_r && rd_mac == mac_r && !m_found_r) begin
        m_found_r <= 1'b1;
        m_idx_r   <= rd_idx_r;
        m_age_r   <= rd_age;
      end
      if (!rd_vbit_r && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
      if (rd_vbit_r && (!old_seen_r || rd_age > old_age_r)) begin
        old_seen_r <= 1'b1;
        old_idx_r  <= rd_idx_r;
        old_age_r  <= rd_age;
      end
    end
  end

  // Replacement choice and result build
  logic [IDX_W-1:0]            tgt_r;
  logic [AGE_W-1:0]            lim_r;
  logic                        nolim_r;
  logic                        res_hit_r;
  logic [arpc_pkg::MAC_W-1:0]  res_mac_r;
  logic [IDX_W-1:0]            res_idx_r;
  logic                        res_ev_r;
  logic [IDX_W+arpc_pkg::SLOT_W-1:0] res_idx_ext;

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_mac_r <= '0;
      res_ev_r  <= 1'b0;
      nolim_r   <= 1'b0;
      if (is_lookup) begin
        res_hit_r <= m_found_r;
        res_idx_r <= m_found_r ? m_idx_r : '0;
        if (m_found_r) res_mac_r <= m_mac_r;
      end else if (m_found_r) begin
        res_hit_r <= 1'b1;
        res_idx_r <= m_idx_r;
        tgt_r     <= m_idx_r;
        lim_r     <= m_age_r;
      end else if (free_found_r) begin
        res_hit_r <= 1'b0;
        res_idx_r <= free_idx_r;
        tgt_r     <= free_idx_r;
        nolim_r   <= 1'b1;
      end else begin
        res_hit_r <= 1'b0;
        res_ev_r  <= 1'b1;
        res_idx_r <= old_idx_r;
        tgt_r     <= old_idx_r;
        lim_r     <= old_age_r;
      end
    end
  end

  // Promote pass: target takes the pair at rank 0, younger entries age by one
  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd_data_r;
    if (prom_ev) begin
      if (rd_idx_r == tgt_r) begin
        wr_en   = 1'b1;
        wr_data = {ip_r, mac_r, {AGE_W{1'b0}}};
      end else if (rd_vbit_r && (nolim_r || rd_age < lim_r)) begin
        wr_en   = 1'b1;
        wr_data = {rd_ip, rd_mac, AGE_W'(rd_age + 1'b1)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (prom_ev && rd_idx_r == tgt_r) begin
      valid_r[rd_idx_r] <= 1'b1;
    end
  end

  // Output register
  logic                         out_valid_r;
  logic                         out_hit_r;
  logic [arpc_pkg::MAC_W-1:0]   out_mac_r;
  logic [arpc_pkg::SLOT_W-1:0]  out_slot_r;
  logic                         out_ev_r;

  assign res_idx_ext = {{arpc_pkg::SLOT_W{1'b0}}, res_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_hit_r  <= res_hit_r;
      out_mac_r  <= res_mac_r;
      out_slot_r <= res_idx_ext[arpc_pkg::SLOT_W-1:0];
      out_ev_r   <= res_ev_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_found_mac = out_mac_r;
  assign out_slot      = out_slot_r;
  assign out_evicted   = out_ev_r;

  assign sts.last      = (cnt_r == IDX_W'(TABLE_ENTRIES - 1));
  assign sts.is_lookup = is_lookup;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

>>> design/arp_table_lru_cache_unit.sv
// ----------------------------------------------------------------------------
// ARP table cache with least-recently-updated replacement
// Fully associative IPv4-to-MAC table: update refreshes or inserts, lookup
// returns the most recent entry for an IPv4 address.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  ----------------------------------------
//  in        in_valid/in_ready    in_opcode, in_ip_address, in_mac_address
//  out       out_valid/out_ready  out_hit, out_found_mac, out_slot,
//                                 out_evicted
//
// The entry memory has one read port, so the scan and the recency update each
// walk the table one entry per cycle; a lookup does only the scan.
// The next request is accepted at the edge after its result is published.
// Reset clears the valid bits at once; no clearing pass is needed.
// A waiting result sits in the output register while the next request is
// accepted; a finished request holds in its last state until that register
// frees up.
//
module arp_table_lru_cache_unit #(
  parameter int TABLE_ENTRIES = arpc_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic [arpc_pkg::IP_W-1:0]    in_ip_address,
  input  logic [arpc_pkg::MAC_W-1:0]   in_mac_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic [arpc_pkg::MAC_W-1:0]   out_found_mac,
  output logic [arpc_pkg::SLOT_W-1:0]  out_slot,
  output logic                         out_evicted
);

  `include "arp_table_lru_cache_unit_macros.svh"

  arpc_pkg::cmd_t cmd;
  arpc_pkg::sts_t sts;

  // Controller: walks each request through scan, decide, promote (updates only), hand-off
  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: entry memory, trackers and output register
  arpc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_ip_address  (in_ip_address),
    .in_mac_address (in_mac_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_found_mac  (out_found_mac),
    .out_slot       (out_slot),
    .out_evicted    (out_evicted)
  );

  // An accepted request makes the block busy on the next cycle.
  `ARPC_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready after accept")
  // A result is moved out only into a free output register.
  `ARPC_ASSERT(a_publish_free, cmd.publish |-> sts.out_free, "publish into full output")
  // An eviction never comes with a refresh hit.
  `ARPC_ASSERT_NEVER(a_hit_evict, out_valid && out_hit && out_evicted, "hit and evicted")

endmodule
